// ===== rtl/mct_pkg.sv =====
// Shared constants for the multichannel compare timer.
// No dependencies.
package mct_pkg;
  localparam int unsigned NUM_CHANNELS_DEF    = 4;
  localparam int unsigned MAX_TICK_CYCLES_DEF = 1024;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [11:0] OFF_STATUS = 12'h080;
  localparam logic [11:0] OFF_ENABLE = 12'h084;
  localparam logic [11:0] OFF_CAP    = 12'h088;
  localparam logic [11:0] LAST_BYTE  = 12'h08B;

  localparam logic [4:0] REG_COUNT = 5'h00;
  localparam logic [4:0] REG_CMP1  = 5'h04;
  localparam logic [4:0] REG_CMP2  = 5'h08;
  localparam logic [4:0] REG_CTRL  = 5'h0C;

  localparam logic [15:0] CAP_VERSION = 16'h0001;
  localparam logic [7:0]  CAP_WIDTH   = 8'd32;

  typedef struct packed {
    logic [31:0] count;
    logic        event_hit;
  } mct_step_t;
endpackage

// ===== rtl/multichannel_compare_timer.sv =====
// Multichannel compare timer: register file, bus decode and tick sequencer.
// Depends on mct_pkg and mct_step_unit.
// Latency: read, write and other ops give their result 1 cycle after the item is accepted.
// Tick: each channel takes 1 load cycle; an enabled channel adds 1 cycle per prescaled step
// (one pass of the shared step unit each) plus 1 closing cycle, so NUM_CHANNELS + enabled
// channels + total steps cycles, at most NUM_CHANNELS * (MAX_TICK_CYCLES + 2).
// One item at a time: input is ready again the cycle after the result is taken.
// Reset (rst_ni low, async): all registers, accumulators and status clear to zero.
module multichannel_compare_timer
  import mct_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS    = NUM_CHANNELS_DEF,
  parameter int unsigned MAX_TICK_CYCLES = MAX_TICK_CYCLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [11:0] address_i,
  input  logic [2:0]  size_bytes_i,
  input  logic [31:0] write_data_i,
  input  logic [10:0] tick_cycles_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        bus_error_o,
  output logic [3:0]  irq_lines_o
);
  localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // accumulator holds < divisor + max tick
  localparam int unsigned ACC_W = $clog2(65536 + MAX_TICK_CYCLES);
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
  localparam logic [ACC_W-1:0] MAX_CYC = ACC_W'(MAX_TICK_CYCLES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;

  logic [31:0] cnt_q  [NUM_CHANNELS];
  logic [31:0] cmp1_q [NUM_CHANNELS];
  logic [31:0] cmp2_q [NUM_CHANNELS];
  logic [31:0] ctrl_q [NUM_CHANNELS];
  logic [ACC_W-1:0] acc_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] status_q;
  logic [31:0] enable_q;

  logic [1:0]       state_q;
  logic [CH_W-1:0]  ch_q;
  logic [ACC_W-1:0] cyc_q;
  logic             hit_q;
  logic             out_valid_q;
  logic [31:0]      rd_q;
  logic             err_q;

  logic             accept;
  logic [2:0]       addr_ch;
  logic             ch_ok;
  logic [CH_W-1:0]  idx;
  logic [4:0]       off;
  logic [31:0]      mask;
  logic [31:0]      wval;
  logic [31:0]      rdata;
  logic [ACC_W-1:0] cyc_sat;
  logic [ACC_W-1:0] div;
  logic [ACC_W-1:0] acc_cur;
  mct_step_t        step;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign read_data_o = rd_q;
  assign bus_error_o = err_q;
  // state holds while a result waits, so the level can be shown directly
  assign irq_lines_o = 4'(status_q & enable_q[NUM_CHANNELS-1:0]);

  assign addr_ch = {1'b0, address_i[6:5]};
  assign ch_ok   = (address_i < OFF_STATUS) && (addr_ch < 3'(NUM_CHANNELS));
  assign off     = address_i[4:0];
  // one shared read port: sequencer channel when busy, bus channel otherwise
  assign idx     = (state_q == S_IDLE) ? CH_W'(address_i[6:5]) : ch_q;
  assign div     = ACC_W'({1'b0, ctrl_q[idx][31:16]}) + ACC_W'(1);
  assign acc_cur = acc_q[idx];

  always_comb begin
    unique case (size_bytes_i)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end
  assign wval = write_data_i & mask;

  always_comb begin
    rdata = 32'd0;
    if (address_i == OFF_STATUS) begin
      rdata = 32'(status_q);
    end else if (address_i == OFF_ENABLE) begin
      rdata = enable_q;
    end else if (address_i == OFF_CAP) begin
      rdata = {CAP_VERSION, 8'(NUM_CHANNELS), CAP_WIDTH};
    end else if (ch_ok) begin
      unique case (off)
        REG_COUNT: rdata = cnt_q[idx];
        REG_CMP1:  rdata = cmp1_q[idx];
        REG_CMP2:  rdata = cmp2_q[idx];
        REG_CTRL:  rdata = ctrl_q[idx];
        default:   rdata = 32'd0;
      endcase
    end
  end

  // zero counts as one, long ticks saturate
  always_comb begin
    if (tick_cycles_i == 11'd0) begin
      cyc_sat = ACC_W'(1);
    end else if (ACC_W'(tick_cycles_i) > MAX_CYC) begin
      cyc_sat = MAX_CYC;
    end else begin
      cyc_sat = ACC_W'(tick_cycles_i);
    end
  end

  mct_step_unit u_step (
    .count_i (cnt_q[idx]),
    .cmp1_i  (cmp1_q[idx]),
    .cmp2_i  (cmp2_q[idx]),
    .step_o  (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt_q[i]  <= '0;
        cmp1_q[i] <= '0;
        cmp2_q[i] <= '0;
        ctrl_q[i] <= '0;
        acc_q[i]  <= '0;
      end
      status_q    <= '0;
      enable_q    <= '0;
      state_q     <= S_IDLE;
      ch_q        <= '0;
      cyc_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      rd_q        <= '0;
      err_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            rd_q  <= 32'd0;
            err_q <= 1'b0;
            if ((op_i == OP_READ || op_i == OP_WRITE) && address_i > LAST_BYTE) begin
              err_q       <= 1'b1;
              out_valid_q <= 1'b1;
            end else if (op_i == OP_READ) begin
              rd_q        <= rdata & mask;
              out_valid_q <= 1'b1;
            end else if (op_i == OP_WRITE) begin
              out_valid_q <= 1'b1;
              if (address_i == OFF_STATUS) begin
                status_q <= status_q & ~wval[NUM_CHANNELS-1:0];
              end else if (address_i == OFF_ENABLE) begin
                enable_q <= wval;
              end else if (ch_ok) begin
                unique case (off)
                  REG_COUNT: cnt_q[idx]  <= wval;
                  REG_CMP1:  cmp1_q[idx] <= wval;
                  REG_CMP2:  cmp2_q[idx] <= wval;
                  REG_CTRL: begin
                    ctrl_q[idx] <= wval;
                    acc_q[idx]  <= '0;
                  end
                  default: ;
                endcase
              end
            end else if (op_i == OP_TICK) begin
              ch_q    <= '0;
              cyc_q   <= cyc_sat;
              state_q <= S_LOAD;
            end else begin
              out_valid_q <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          hit_q <= 1'b0;
          if (ctrl_q[idx][0]) begin
            acc_q[idx] <= acc_cur + cyc_q;
            state_q    <= S_STEP;
          end else if (ch_q == LAST_CH) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end else begin
            ch_q <= ch_q + CH_W'(1);
          end
        end
        S_STEP: begin
          // one prescaled step per cycle until the remainder is below the divisor
          if (acc_cur >= div) begin
            acc_q[idx] <= acc_cur - div;
            cnt_q[idx] <= step.count;
            if (step.event_hit && ctrl_q[idx][3]) hit_q <= 1'b1;
          end else begin
            if (hit_q) status_q[idx] <= 1'b1;
            if (ch_q == LAST_CH) begin
              state_q     <= S_IDLE;
              out_valid_q <= 1'b1;
            end else begin
              ch_q    <= ch_q + CH_W'(1);
              state_q <= S_LOAD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/mct_step_unit.sv =====
// Shared counter step unit: one prescaled increment with reload and match.
// Depends on mct_pkg.
module mct_step_unit
  import mct_pkg::*;
(
  input  logic [31:0] count_i,
  input  logic [31:0] cmp1_i,
  input  logic [31:0] cmp2_i,
  output mct_step_t   step_o
);
  logic [31:0] inc;
  always_comb begin
    inc = count_i + 32'd1;
    step_o.count     = inc;
    step_o.event_hit = 1'b0;
    if (cmp2_i != 32'd0 && inc > cmp2_i) begin
      step_o.count     = inc - cmp2_i;
      step_o.event_hit = 1'b1;
    end else if (cmp1_i != 32'd0 && inc >= cmp1_i) begin
      step_o.event_hit = 1'b1;
    end
  end
endmodule
